FILE: sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, gated by the active-low reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, gated by the active-low reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/qxv_pkg.sv
// types and constants for the x1 quadrature counter with velocity output
`timescale 1ns / 1ps

package qxv_pkg;

  localparam int COUNT_WIDTH = 32;

  localparam logic [31:0] WINDOW_TICKS_RST       = 32'd1000000;
  localparam logic [31:0] VELOCITY_PER_COUNT_RST = 32'd5663;

  typedef enum logic [0:0] {
    CFG_WINDOW_TICKS       = 1'b0,
    CFG_VELOCITY_PER_COUNT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic chan_a;
    logic chan_b;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] speed;
    logic signed [31:0] window_delta;
    logic signed [31:0] position;
  } out_item_t;

  // closed window handed from the counter to the scaler
  typedef struct packed {
    logic                          valid;
    logic signed [COUNT_WIDTH-1:0] delta;
    logic signed [COUNT_WIDTH-1:0] pos;
  } window_close_t;

endpackage

FILE: sv/qxv_counter.sv
// edge detection, position count and window timing
`timescale 1ns / 1ps

module qxv_counter (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic                     adv,
  input  qxv_pkg::in_item_t        item,
  input  logic [31:0]              window_ticks,
  output qxv_pkg::window_close_t   close_out
);

  logic                                    prev_a_r;
  logic signed [qxv_pkg::COUNT_WIDTH-1:0]  pos_r;
  logic signed [qxv_pkg::COUNT_WIDTH-1:0]  pos_nxt;
  logic signed [qxv_pkg::COUNT_WIDTH-1:0]  start_r;
  logic [31:0]                             tick_r;
  logic [31:0]                             tick_inc;
  logic [31:0]                             limit;
  logic                                    close;
  qxv_pkg::window_close_t                  close_r;

  always_comb begin
    pos_nxt = pos_r;
    if (!prev_a_r && item.chan_a) begin
      if (item.chan_b) begin
        pos_nxt = pos_r - qxv_pkg::COUNT_WIDTH'(1);
      end else begin
        pos_nxt = pos_r + qxv_pkg::COUNT_WIDTH'(1);
      end
    end
  end

  // a zero length acts as one tick
  assign limit    = (window_ticks == 32'd0) ? 32'd1 : window_ticks;
  assign tick_inc = tick_r + 32'd1;
  assign close    = (tick_inc >= limit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_r <= 1'b1;
      pos_r    <= '0;
      start_r  <= '0;
      tick_r   <= '0;
    end else if (accept) begin
      prev_a_r <= item.chan_a;
      pos_r    <= pos_nxt;
      if (close) begin
        tick_r  <= '0;
        start_r <= pos_nxt;
      end else begin
        tick_r  <= tick_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      close_r.valid <= 1'b0;
    end else if (adv) begin
      close_r.valid <= accept && close;
      close_r.delta <= pos_nxt - start_r;
      close_r.pos   <= pos_nxt;
    end
  end

  assign close_out = close_r;

endmodule

FILE: sv/qxv_scale.sv
// delta times factor, then signed 32-bit saturation into the result register
`timescale 1ns / 1ps

module qxv_scale (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  qxv_pkg::window_close_t close_in,
  input  logic [31:0]            factor,
  output logic                   out_valid,
  output qxv_pkg::out_item_t     out_item
);

  logic [qxv_pkg::COUNT_WIDTH-1:0]         mag;
  logic [31:0]                             mag_c;
  logic [63:0]                             prod;
  logic                                    neg;

  logic                                    mul_valid_r;
  logic                                    neg_r;
  logic [63:0]                             prod_r;
  logic signed [qxv_pkg::COUNT_WIDTH-1:0]  delta_r;
  logic signed [qxv_pkg::COUNT_WIDTH-1:0]  pos_r;

  logic [31:0]                             sat;
  logic                                    out_valid_r;
  qxv_pkg::out_item_t                      out_item_r;

  assign neg = close_in.delta[qxv_pkg::COUNT_WIDTH-1];
  assign mag = neg ? qxv_pkg::COUNT_WIDTH'(-close_in.delta)
                   : qxv_pkg::COUNT_WIDTH'(close_in.delta);

  // anything beyond 2^31 saturates either way
  assign mag_c = (64'(mag) > 64'h8000_0000) ? 32'h8000_0000 : 32'(mag);
  assign prod  = 64'(mag_c) * 64'(factor);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else if (adv) begin
      mul_valid_r <= close_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg_r   <= neg;
      prod_r  <= prod;
      delta_r <= close_in.delta;
      pos_r   <= close_in.pos;
    end
  end

  always_comb begin
    if (neg_r) begin
      sat = (prod_r > 64'h8000_0000) ? 32'h8000_0000 : prod_r[31:0];
      sat = -sat;
    end else begin
      sat = (prod_r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : prod_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r.speed        <= $signed(sat);
      out_item_r.window_delta <= 32'(delta_r);
      out_item_r.position     <= 32'(pos_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: sv/quadrature_x1_counter_velocity_top.sv
// top level of the x1 quadrature counter with windowed velocity output
`timescale 1ns / 1ps

// x1 quadrature encoder counter. every accepted item is one sample of the
// a and b channel levels; a rising edge of a counts up when b is low and
// down when b is high, into a wrapping signed position count. every
// window_ticks accepted items a window closes and one result item comes
// out: the count change over the window, the position at the close, and
// speed = change * velocity_per_count (q16.16), saturated to signed 32 bits.
// a window_ticks of zero behaves as one. an item is taken every cycle while
// the output is not held back; a result appears once the item that closes
// its window has passed the counter register, multiplier register and
// result register, the 32x32 multiplier feeding the middle stage. the whole
// pipeline holds while a result sits stalled at the output. configuration
// writes are always taken and should only be made while the block is idle.

module quadrature_x1_counter_velocity_top (
  input  logic                 clk,
  input  logic                 rst_n,
  // sample items
  input  logic                 in_valid,
  output logic                 in_stall,
  input  qxv_pkg::in_item_t    in_item,
  // result items
  output logic                 out_valid,
  input  logic                 out_stall,
  output qxv_pkg::out_item_t   out_item,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  qxv_pkg::cfg_index_t  cfg_index,
  input  logic [31:0]          cfg_data
);

  logic                   adv;
  logic                   accept;
  logic [31:0]            window_ticks_r;
  logic [31:0]            velocity_per_count_r;
  qxv_pkg::window_close_t close_s;

  // the pipeline moves unless a finished result is held at the output
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_ticks_r       <= qxv_pkg::WINDOW_TICKS_RST;
      velocity_per_count_r <= qxv_pkg::VELOCITY_PER_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        qxv_pkg::CFG_WINDOW_TICKS:       window_ticks_r       <= cfg_data;
        qxv_pkg::CFG_VELOCITY_PER_COUNT: velocity_per_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // edge counting and window close
  qxv_counter u_counter (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .adv          (adv),
    .item         (in_item),
    .window_ticks (window_ticks_r),
    .close_out    (close_s)
  );

  // scaling, saturation and result register
  qxv_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .close_in  (close_s),
    .factor    (velocity_per_count_r),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

FILE: sv/qxv_checker.sv
// port-level checks for the quadrature velocity block, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module qxv_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input qxv_pkg::out_item_t  out_item
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item), "stalled result changed")
  `ASSERT_IMPLIES(a_zero_delta, clk, rst_n, out_valid && out_item.window_delta == 32'sd0, out_item.speed == 32'sd0, "nonzero speed with zero delta")
  `ASSERT_IMPLIES(a_pos_sign, clk, rst_n, out_valid && !out_item.window_delta[31], !out_item.speed[31], "negative speed for forward motion")
  `ASSERT_IMPLIES(a_neg_sign, clk, rst_n, out_valid && out_item.window_delta[31], out_item.speed[31] || out_item.speed == 32'sd0, "positive speed for reverse motion")

endmodule

bind quadrature_x1_counter_velocity_top qxv_checker u_qxv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
